// ===== design/smr_pkg.sv =====
// Shared constants for the spiral matrix readout core.
// Register indexes, heading codes, default sizes and port field widths.
// No dependencies.
`timescale 1ns / 1ps

package smr_pkg;

    // Default sizes for the top-level parameters
    localparam int MAX_DIM_DEF    = 32;
    localparam int DATA_WIDTH_DEF = 32;

    // Configuration port
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

    localparam logic [CFG_W-1:0] DIM_RESET = 6'd32;

    // Walk headings, turning left in this order
    localparam logic [1:0] HEAD_DOWN  = 2'd0;
    localparam logic [1:0] HEAD_RIGHT = 2'd1;
    localparam logic [1:0] HEAD_UP    = 2'd2;
    localparam logic [1:0] HEAD_LEFT  = 2'd3;

    // Result word fields
    localparam int OUT_DATA_W = 32;
    localparam int OUT_POS_W  = 5;
    localparam int M_TDATA_W  = 48;

endpackage

// ===== design/spiral_matrix_readout_core.sv =====
// Spiral matrix readout core: loads a matrix row-major, reads it back in
// spiral order. Depends on smr_pkg.
// Fetch path: an accepted fetch reads into mem_q and the pending stage, then moves to the result stage.
// Throughput: one word per cycle, loads and fetches alike, unless fetch data waits on
// a blocked one-deep result stage; set by the single synchronous matrix memory read port.
// Reset: clears all control state and sets both dimensions to 32, or to MAX_DIM if
// smaller; the matrix memory is not cleared and holds undefined data until loaded.
`timescale 1ns / 1ps

module spiral_matrix_readout_core #(
    parameter int MAX_DIM    = smr_pkg::MAX_DIM_DEF,
    parameter int DATA_WIDTH = smr_pkg::DATA_WIDTH_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    // Configuration write port
    input  logic                                      cfg_we,
    input  logic [smr_pkg::CFG_IDX_W-1:0]             cfg_index,
    input  logic [smr_pkg::CFG_W-1:0]                 cfg_data,
    // Input stream
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // s_tdata fields: data_in (DATA_WIDTH bits), zero pad to whole bytes
    input  logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0]   s_tdata,
    // s_tuser fields: func (1 bit)
    input  logic                                      s_tuser,
    // Output stream
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // m_tdata fields: data_out [31:0], out_row [36:32], out_col [41:37], zero pad
    output logic [smr_pkg::M_TDATA_W-1:0]             m_tdata,
    // is_last
    output logic                                      m_tlast
);
    import smr_pkg::*;

    // Dimensions above 63 cannot be written through a 6-bit register
    localparam int DIM_CAP  = (MAX_DIM < 63) ? MAX_DIM : 63;
    localparam int DIM_W    = $clog2(DIM_CAP + 1);
    localparam int POS_W    = (DIM_CAP > 1) ? $clog2(DIM_CAP) : 1;
    localparam int ADDR_W   = (DIM_CAP > 1) ? $clog2(DIM_CAP * DIM_CAP) : 1;
    localparam int DEPTH    = DIM_CAP * DIM_CAP;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int PAD_W    = M_TDATA_W - OUT_DATA_W - 2 * OUT_POS_W;
    localparam int DIM_RST  = (32 < DIM_CAP) ? 32 : DIM_CAP;

    // Clamp a raw register value into the usable range: zero reads as one
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] raw);
        logic [DIM_W-1:0] res;
        if (raw == '0)
            res = DIM_W'(1);
        else if (raw > CFG_W'(DIM_CAP))
            res = DIM_W'(DIM_CAP);
        else
            res = DIM_W'(raw);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Configuration and walk state
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] rows_eff_reg, cols_eff_reg;
    logic [POS_W-1:0] load_row_reg, load_col_reg;
    logic             loaded_reg;
    logic [CNT_W-1:0] emit_cnt_reg;
    logic [POS_W-1:0] cur_row_reg, cur_col_reg;
    logic [1:0]       heading_reg;
    logic [POS_W-1:0] top_reg, bottom_reg, left_reg, right_reg;

    // Matrix memory and its registered read data
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] mem_q;

    // Fetch in flight (read data lands in mem_q) and result stage
    logic                  pend_reg;
    logic [OUT_POS_W-1:0]  pend_row_reg, pend_col_reg;
    logic                  pend_last_reg;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_POS_W-1:0]  out_row_reg, out_col_reg;
    logic                  out_last_reg;

    logic out_free, pend_move, in_go, load_go, fetch_go, fetch_last;
    logic load_row_end, load_last;
    logic [CNT_W-1:0]  total;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [DIM_W-1:0]  rows_cfg, cols_cfg;

    // Next walk position after the current cell
    logic [POS_W-1:0] row_next, col_next;
    logic [POS_W-1:0] top_next, bottom_next, left_next, right_next;
    logic [1:0]       heading_next;

    // Result stage frees up when empty or draining this cycle
    assign out_free  = !out_valid_reg || m_tready;
    assign pend_move = pend_reg && out_free;
    // Stall input only while read data waits on a blocked result stage
    assign s_tready  = !pend_reg || out_free;
    assign in_go     = s_tvalid && s_tready;

    // Loads are dropped once the matrix is full; fetches are dropped until it is full
    assign load_go  = in_go && !s_tuser && !loaded_reg;
    assign fetch_go = in_go && s_tuser && loaded_reg;

    assign total      = CNT_W'(rows_eff_reg * cols_eff_reg);
    assign fetch_last = (emit_cnt_reg + CNT_W'(1)) == total;

    assign load_row_end = load_col_reg == POS_W'(cols_eff_reg - DIM_W'(1));
    assign load_last    = load_row_end && (load_row_reg == POS_W'(rows_eff_reg - DIM_W'(1)));

    assign wr_addr = ADDR_W'(load_row_reg * DIM_CAP + load_col_reg);
    assign rd_addr = ADDR_W'(cur_row_reg * DIM_CAP + cur_col_reg);

    // A write to either register rearms the walk with the new dimensions
    assign rows_cfg = (cfg_index == REG_ROW_COUNT) ? clamp_dim(cfg_data) : rows_eff_reg;
    assign cols_cfg = (cfg_index == REG_COL_COUNT) ? clamp_dim(cfg_data) : cols_eff_reg;

    // Step the spiral: go straight while inside the bounds, else turn left
    // and shrink the bound just finished
    always_comb
    begin
        row_next     = cur_row_reg;
        col_next     = cur_col_reg;
        heading_next = heading_reg;
        top_next     = top_reg;
        bottom_next  = bottom_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        case (heading_reg)
            HEAD_DOWN:
            begin
                if (cur_row_reg < bottom_reg)
                    row_next = cur_row_reg + POS_W'(1);
                else
                begin
                    left_next    = left_reg + POS_W'(1);
                    heading_next = HEAD_RIGHT;
                    col_next     = cur_col_reg + POS_W'(1);
                end
            end
            HEAD_RIGHT:
            begin
                if (cur_col_reg < right_reg)
                    col_next = cur_col_reg + POS_W'(1);
                else
                begin
                    bottom_next  = bottom_reg - POS_W'(1);
                    heading_next = HEAD_UP;
                    row_next     = cur_row_reg - POS_W'(1);
                end
            end
            HEAD_UP:
            begin
                if (cur_row_reg > top_reg)
                    row_next = cur_row_reg - POS_W'(1);
                else
                begin
                    right_next   = right_reg - POS_W'(1);
                    heading_next = HEAD_LEFT;
                    col_next     = cur_col_reg - POS_W'(1);
                end
            end
            default:
            begin
                if (cur_col_reg > left_reg)
                    col_next = cur_col_reg - POS_W'(1);
                else
                begin
                    top_next     = top_reg + POS_W'(1);
                    heading_next = HEAD_DOWN;
                    row_next     = cur_row_reg + POS_W'(1);
                end
            end
        endcase
    end

    // Control state: dimensions, load counters, walk position and bounds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_eff_reg <= DIM_W'(DIM_RST);
            cols_eff_reg <= DIM_W'(DIM_RST);
            load_row_reg <= '0;
            load_col_reg <= '0;
            loaded_reg   <= 1'b0;
            emit_cnt_reg <= '0;
            cur_row_reg  <= '0;
            cur_col_reg  <= '0;
            heading_reg  <= HEAD_DOWN;
            top_reg      <= '0;
            left_reg     <= '0;
            bottom_reg   <= POS_W'(DIM_RST - 1);
            right_reg    <= POS_W'(DIM_RST - 1);
        end
        else if (cfg_we)
        begin
            rows_eff_reg <= rows_cfg;
            cols_eff_reg <= cols_cfg;
            load_row_reg <= '0;
            load_col_reg <= '0;
            loaded_reg   <= 1'b0;
            emit_cnt_reg <= '0;
            cur_row_reg  <= '0;
            cur_col_reg  <= '0;
            heading_reg  <= HEAD_DOWN;
            top_reg      <= '0;
            left_reg     <= '0;
            bottom_reg   <= POS_W'(rows_cfg - DIM_W'(1));
            right_reg    <= POS_W'(cols_cfg - DIM_W'(1));
        end
        else if (load_go)
        begin
            // Advance the row-major fill position; hold it at the last cell
            if (load_last)
                loaded_reg <= 1'b1;
            else if (load_row_end)
            begin
                load_col_reg <= '0;
                load_row_reg <= load_row_reg + POS_W'(1);
            end
            else
                load_col_reg <= load_col_reg + POS_W'(1);
        end
        else if (fetch_go)
        begin
            if (fetch_last)
            begin
                // Rearm for the next matrix
                load_row_reg <= '0;
                load_col_reg <= '0;
                loaded_reg   <= 1'b0;
                emit_cnt_reg <= '0;
                cur_row_reg  <= '0;
                cur_col_reg  <= '0;
                heading_reg  <= HEAD_DOWN;
                top_reg      <= '0;
                left_reg     <= '0;
                bottom_reg   <= POS_W'(rows_eff_reg - DIM_W'(1));
                right_reg    <= POS_W'(cols_eff_reg - DIM_W'(1));
            end
            else
            begin
                emit_cnt_reg <= emit_cnt_reg + CNT_W'(1);
                cur_row_reg  <= row_next;
                cur_col_reg  <= col_next;
                heading_reg  <= heading_next;
                top_reg      <= top_next;
                bottom_reg   <= bottom_next;
                left_reg     <= left_next;
                right_reg    <= right_next;
            end
        end
    end

    // Matrix memory: one write and one registered read per cycle. Loads and
    // fetches never overlap, so no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (load_go)
            mem[wr_addr] <= s_tdata[DATA_WIDTH-1:0];
        if (fetch_go)
            mem_q <= mem[rd_addr];
    end

    // Fetch in flight: hold position and last flag beside the memory read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 1'b0;
        else if (fetch_go)
            pend_reg <= 1'b1;
        else if (pend_move)
            pend_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fetch_go)
        begin
            pend_row_reg  <= OUT_POS_W'(cur_row_reg);
            pend_col_reg  <= OUT_POS_W'(cur_col_reg);
            pend_last_reg <= fetch_last;
        end
    end

    // Result stage: take read data as it lands, drop it when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pend_move)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pend_move)
        begin
            out_data_reg <= OUT_DATA_W'(mem_q);
            out_row_reg  <= pend_row_reg;
            out_col_reg  <= pend_col_reg;
            out_last_reg <= pend_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_col_reg, out_row_reg, out_data_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== tb/spiral_tb_pkg.sv =====
// Testbench-side codes for the spiral matrix readout core: word kinds on
// s_tuser and the rule that maps a dimension register to the size in use.
// Depends on smr_pkg.
`timescale 1ns / 1ps

package spiral_tb_pkg;

    // Word kinds carried on s_tuser
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    // Zero acts as one, anything above the largest size acts as the largest
    function automatic int dim_in_use(logic [smr_pkg::CFG_W-1:0] raw);
        if (raw == '0)
            return 1;
        if (int'(raw) > smr_pkg::MAX_DIM_DEF)
            return smr_pkg::MAX_DIM_DEF;
        return int'(raw);
    endfunction

endpackage

// ===== tb/spiral_readout_checker.sv =====
// Checker for the spiral matrix readout core: tracks configuration, loads
// and fetches, predicts each result word and compares it on the output.
// Depends on smr_pkg and spiral_tb_pkg.
`timescale 1ns / 1ps

module spiral_readout_checker
    import smr_pkg::*;
    import spiral_tb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [31:0]           s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  m_tlast,
    output int                    mismatch_count,
    output int                    words_due
);

    typedef struct packed {
        logic [OUT_DATA_W-1:0] value;
        logic [OUT_POS_W-1:0]  row;
        logic [OUT_POS_W-1:0]  col;
        logic                  last;
    } readout_t;

    readout_t readouts_due[$];

    logic [CFG_W-1:0]      rows_reg;
    logic [CFG_W-1:0]      cols_reg;
    logic [OUT_DATA_W-1:0] grid_mem [0:MAX_DIM_DEF-1][0:MAX_DIM_DEF-1];
    int                    loaded;
    int                    emitted;
    int                    cur_r;
    int                    cur_c;
    int                    top_b;
    int                    bot_b;
    int                    left_b;
    int                    right_b;
    logic [1:0]            walk_dir;

    task automatic report_mismatch(string msg);
        $display("spiral check @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic rearm_walk();
        loaded   = 0;
        emitted  = 0;
        cur_r    = 0;
        cur_c    = 0;
        walk_dir = HEAD_DOWN;
        top_b    = 0;
        left_b   = 0;
        bot_b    = dim_in_use(rows_reg) - 1;
        right_b  = dim_in_use(cols_reg) - 1;
    endtask

    // Step to the next spiral position, turning left and pulling in a bound
    // at each edge
    task automatic walk_step();
        case (walk_dir)
            HEAD_DOWN:
            begin
                if (cur_r < bot_b)
                    cur_r++;
                else
                begin
                    left_b++;
                    walk_dir = HEAD_RIGHT;
                    cur_c++;
                end
            end
            HEAD_RIGHT:
            begin
                if (cur_c < right_b)
                    cur_c++;
                else
                begin
                    bot_b--;
                    walk_dir = HEAD_UP;
                    cur_r--;
                end
            end
            HEAD_UP:
            begin
                if (cur_r > top_b)
                    cur_r--;
                else
                begin
                    right_b--;
                    walk_dir = HEAD_LEFT;
                    cur_c--;
                end
            end
            default:
            begin
                if (cur_c > left_b)
                    cur_c--;
                else
                begin
                    top_b++;
                    walk_dir = HEAD_DOWN;
                    cur_r++;
                end
            end
        endcase
    endtask

    task automatic predict_word(logic func, logic [OUT_DATA_W-1:0] value);
        int       ncols;
        int       total;
        readout_t r;
        ncols = dim_in_use(cols_reg);
        total = dim_in_use(rows_reg) * ncols;
        if (func == FUNC_LOAD)
        begin
            // Loads past a full matrix are dropped
            if (loaded < total)
            begin
                grid_mem[loaded / ncols][loaded % ncols] = value;
                loaded++;
            end
        end
        else if (loaded == total && emitted < total)
        begin
            r.value = grid_mem[cur_r][cur_c];
            r.row   = cur_r[OUT_POS_W-1:0];
            r.col   = cur_c[OUT_POS_W-1:0];
            r.last  = (emitted + 1 == total);
            readouts_due.push_back(r);
            if (r.last)
                rearm_walk();
            else
            begin
                emitted++;
                walk_step();
            end
        end
    endtask

    task automatic check_word();
        readout_t e;
        if (readouts_due.size() == 0)
        begin
            report_mismatch($sformatf("result word with no fetch waiting: %h", m_tdata));
            return;
        end
        e = readouts_due.pop_front();
        if (m_tdata[31:0] !== e.value)
            report_mismatch($sformatf("data_out %h, want %h", m_tdata[31:0], e.value));
        if (m_tdata[36:32] !== e.row)
            report_mismatch($sformatf("out_row %0d, want %0d", m_tdata[36:32], e.row));
        if (m_tdata[41:37] !== e.col)
            report_mismatch($sformatf("out_col %0d, want %0d", m_tdata[41:37], e.col));
        if (m_tlast !== e.last)
            report_mismatch($sformatf("is_last %b, want %b", m_tlast, e.last));
        if (m_tdata[M_TDATA_W-1:42] !== '0)
            report_mismatch($sformatf("pad bits %h not zero", m_tdata[M_TDATA_W-1:42]));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mismatch_count = 0;
            rows_reg       = DIM_RESET;
            cols_reg       = DIM_RESET;
            readouts_due.delete();
            rearm_walk();
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_word();
            if (cfg_we)
            begin
                if (cfg_index == REG_ROW_COUNT)
                    rows_reg = cfg_data;
                else
                    cols_reg = cfg_data;
                rearm_walk();
            end
            if (s_tvalid && s_tready)
                predict_word(s_tuser, s_tdata[OUT_DATA_W-1:0]);
        end
        words_due = readouts_due.size();
    end

endmodule

// ===== tb/tb_spiral_matrix_readout_core.sv =====
// Top of the spiral matrix readout testbench: clock, reset, stimulus, the
// output-side stall pattern and the verdict. Depends on smr_pkg,
// spiral_tb_pkg, spiral_readout_checker and the core itself.
`timescale 1ns / 1ps

module tb_spiral_matrix_readout_core;

    import smr_pkg::*;
    import spiral_tb_pkg::*;

    // Generous bound on the whole run
    localparam int CYCLE_LIMIT = 500000;
    // Words that do real work (stored loads, answered fetches) before stopping
    localparam int TARGET_WORDS = 1800;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [31:0]          s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    int mismatch_count;
    int words_due;
    int cycle_count = 0;
    int useful_words = 0;
    bit no_idle = 1'b0;

    // Shadow of the dimension registers, needed to size each matrix
    logic [CFG_W-1:0] rows_raw = DIM_RESET;
    logic [CFG_W-1:0] cols_raw = DIM_RESET;

    spiral_matrix_readout_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    spiral_readout_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .words_due      (words_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: a hung handshake or a missing result ends up here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Output side: before each result word hold tready low for a random
    // stall, then keep it high until a word is taken. Handshakes are judged
    // on the falling edge, where every signal has settled for the next rise.
    initial
    begin
        int stall;
        bit took;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
            begin
                @(negedge clk);
                took = m_tvalid;
                @(posedge clk);
            end
            while (!took);
        end
    end

    // Present one input word after a random gap and hold it until accepted.
    // tvalid stays high into the next word when there is no gap.
    task automatic send_word(input logic func, input logic [31:0] value);
        int gap;
        bit took;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= value;
        do
        begin
            @(negedge clk);
            took = s_tready;
            @(posedge clk);
        end
        while (!took);
    endtask

    // Drop tvalid, wait for every predicted result, then let the read
    // pipeline empty so a trailing no-result fetch cannot overlap a write
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (words_due != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        if (idx == REG_ROW_COUNT)
            rows_raw = value;
        else
            cols_raw = value;
    endtask

    // Element values lean on the sign boundary and all-ones/all-zeros
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_extreme_dim();
        case ($urandom_range(0, 4))
            0:       return 6'd0;
            1:       return 6'd1;
            2:       return 6'd32;
            3:       return 6'd33;
            default: return 6'd63;
        endcase
    endfunction

    // Load one matrix and walk it out. Sprinkle in fetches that come too
    // early, a load into a full matrix and a fetch after the walk has
    // rearmed. stop_at >= 0 abandons the matrix at that word so the next
    // register write lands mid-load or mid-walk.
    task automatic run_matrix(input int stop_at);
        int total;
        int k;
        total = dim_in_use(rows_raw) * dim_in_use(cols_raw);
        for (k = 0; k < total; k++)
        begin
            if (k == stop_at)
                return;
            if ($urandom_range(0, 19) == 0)
                send_word(FUNC_FETCH, $urandom);
            send_word(FUNC_LOAD, pick_value());
            useful_words++;
        end
        if ($urandom_range(0, 4) == 0)
            send_word(FUNC_LOAD, $urandom);
        for (k = 0; k < total; k++)
        begin
            if (total + k == stop_at)
                return;
            send_word(FUNC_FETCH, $urandom);
            useful_words++;
        end
        if ($urandom_range(0, 3) == 0)
            send_word(FUNC_FETCH, $urandom);
    endtask

    initial
    begin
        int sel;
        int runs;
        int stop_at;
        logic [CFG_W-1:0] new_rows;
        logic [CFG_W-1:0] new_cols;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = FUNC_LOAD;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a fetch into the empty default-size matrix gets nothing
        send_word(FUNC_FETCH, 32'hffff_ffff);
        drain();

        // 1x1: one load, a load into the full matrix, the only fetch
        // (first and last at once), then a fetch after the walk is done
        write_reg(REG_ROW_COUNT, 6'd1);
        write_reg(REG_COL_COUNT, 6'd1);
        send_word(FUNC_LOAD, 32'h8000_0000);
        send_word(FUNC_LOAD, 32'h7fff_ffff);
        send_word(FUNC_FETCH, 32'h0000_0000);
        send_word(FUNC_FETCH, 32'h5555_aaaa);
        drain();

        // 2x3: walks down, right, up and left once each
        write_reg(REG_ROW_COUNT, 6'd2);
        write_reg(REG_COL_COUNT, 6'd3);
        send_word(FUNC_LOAD, 32'h7fff_ffff);
        send_word(FUNC_LOAD, 32'hffff_ffff);
        send_word(FUNC_LOAD, 32'h0000_0000);
        send_word(FUNC_LOAD, 32'h0000_0001);
        send_word(FUNC_LOAD, 32'h8000_0000);
        send_word(FUNC_LOAD, 32'haaaa_5555);
        repeat (6) send_word(FUNC_FETCH, 32'h0000_0000);
        drain();

        // Random phases: a new size, then one or two matrices at that size
        while (useful_words < TARGET_WORDS)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            sel     = $urandom_range(0, 9);
            if (sel == 0)
            begin
                new_rows = pick_extreme_dim();
                new_cols = CFG_W'($urandom_range(0, 3));
            end
            else if (sel == 1)
            begin
                new_rows = CFG_W'($urandom_range(0, 3));
                new_cols = pick_extreme_dim();
            end
            else
            begin
                new_rows = CFG_W'($urandom_range(1, 8));
                new_cols = CFG_W'($urandom_range(1, 8));
            end

            // Sometimes touch only one register, as long as the other one
            // keeps the matrix small
            if (sel > 1 && $urandom_range(0, 4) == 0 && dim_in_use(cols_raw) <= 8)
                write_reg(REG_ROW_COUNT, new_rows);
            else if (sel > 1 && $urandom_range(0, 4) == 0 && dim_in_use(rows_raw) <= 8)
                write_reg(REG_COL_COUNT, new_cols);
            else
            begin
                write_reg(REG_ROW_COUNT, new_rows);
                write_reg(REG_COL_COUNT, new_cols);
            end

            runs = $urandom_range(1, 2);
            repeat (runs)
            begin
                stop_at = -1;
                if ($urandom_range(0, 9) == 0)
                    stop_at = $urandom_range(0,
                        2 * dim_in_use(rows_raw) * dim_in_use(cols_raw) - 1);
                run_matrix(stop_at);
            end
            drain();
        end

        // Let any stray result show up before judging
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/smr_pkg.sv
design/spiral_matrix_readout_core.sv
tb/spiral_tb_pkg.sv
tb/spiral_readout_checker.sv
tb/tb_spiral_matrix_readout_core.sv
